// ===== rtl/lzwse_pkg.sv =====
package lzwse_pkg;

  // Widths fixed by the stream format.
  localparam int IN_SYM_W  = 7;
  localparam int OUT_CODE_W = 12;

  // Generation mark kept in every hash slot. Mark zero means an empty slot.
  localparam int EPOCH_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;      // write an empty slot at the sweep counter and advance it
    logic first_sym;   // start a new prefix from the incoming symbol
    logic lookup;      // latch the item and read the slot its key hashes to
    logic probe_next;  // read the following slot of the probe chain
    logic hit;         // matched: the stored code becomes the prefix
    logic miss;        // emit the prefix, insert the pair if there is room, restart from the symbol
    logic flush;       // emit the final prefix and close the message
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prefix_valid;
    logic last;        // the item under lookup ends its message
    logic rd_match;    // slot just read holds the searched pair
    logic rd_empty;    // slot just read belongs to no live entry
    logic q_full;      // result queue cannot take another code
    logic clr_done;    // sweep counter is at the last slot
    logic epoch_wrap;  // generation mark is at its top value
  } status_t;

endpackage

// ===== rtl/lzwse_ram.sv =====
module lzwse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lzwse_ctrl.sv =====
module lzwse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end_of_message,
  output logic                in_ready,
  input  lzwse_pkg::status_t  status,
  output lzwse_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (status.prefix_valid) begin
            cmd.lookup = 1'b1;
            state_nxt  = ST_CHECK;
          end else begin
            cmd.first_sym = 1'b1;
            if (in_end_of_message) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_CHECK: begin
        if (status.rd_match) begin
          cmd.hit   = 1'b1;
          state_nxt = status.last ? ST_FLUSH : ST_IDLE;
        end else if (status.rd_empty) begin
          if (!status.q_full) begin
            cmd.miss  = 1'b1;
            state_nxt = status.last ? ST_FLUSH : ST_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status.q_full) begin
          cmd.flush = 1'b1;
          state_nxt = status.epoch_wrap ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lzwse_dp.sv =====
module lzwse_dp #(
  parameter int DICT_SIZE = 4096,
  parameter int ALPHABET  = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lzwse_pkg::IN_SYM_W-1:0]       in_symbol,
  input  logic                                 in_end_of_message,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lzwse_pkg::OUT_CODE_W-1:0]     out_code,
  output logic                                 out_last_code,
  input  lzwse_pkg::cmd_t                      cmd,
  output lzwse_pkg::status_t                   status
);

  localparam int CODE_W    = $clog2(DICT_SIZE);
  localparam int NFC_W     = $clog2(DICT_SIZE + 1);
  localparam int SYM_W     = $clog2(ALPHABET);
  localparam int TBL_AW    = CODE_W + 1;
  localparam int TBL_DEPTH = 2 ** TBL_AW;
  localparam int EP_W      = lzwse_pkg::EPOCH_W;
  localparam int ENTRY_W   = EP_W + CODE_W + SYM_W + CODE_W;
  localparam int IN_VALS   = 2 ** lzwse_pkg::IN_SYM_W;

  // Symbol reduced modulo the alphabet, as a constant lookup table.
  logic [SYM_W-1:0] sym_tbl [IN_VALS];
  for (genvar i = 0; i < IN_VALS; i++) begin : g_sym_tbl
    assign sym_tbl[i] = SYM_W'(i % ALPHABET);
  end

  logic [SYM_W-1:0]  in_sym;
  logic [SYM_W-1:0]  sym_r;
  logic              last_r;
  logic [CODE_W-1:0] prefix_r;
  logic              valid_r;
  logic [NFC_W-1:0]  nfc_r;
  logic [EP_W-1:0]   epoch_r;
  logic [TBL_AW-1:0] probe_r;
  logic [TBL_AW-1:0] clr_r;
  logic [TBL_AW-1:0] hash_in;
  logic              room;

  logic              wr_en, rd_en;
  logic [TBL_AW-1:0] wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;

  logic [EP_W-1:0]   rd_epoch;
  logic [CODE_W-1:0] rd_pfx, rd_code;
  logic [SYM_W-1:0]  rd_sym;

  assign in_sym  = sym_tbl[in_symbol];
  assign hash_in = TBL_AW'(prefix_r) ^ (TBL_AW'(in_sym) << (TBL_AW - SYM_W));
  assign room    = (nfc_r < NFC_W'(DICT_SIZE));

  assign rd_epoch = rd_data[ENTRY_W-1 -: EP_W];
  assign rd_pfx   = rd_data[CODE_W+SYM_W+CODE_W-1 -: CODE_W];
  assign rd_sym   = rd_data[CODE_W +: SYM_W];
  assign rd_code  = rd_data[CODE_W-1:0];

  assign rd_en   = cmd.lookup | cmd.probe_next;
  assign rd_addr = cmd.lookup ? hash_in : probe_r + TBL_AW'(1);
  assign wr_en   = cmd.clr_en | (cmd.miss & room);
  assign wr_addr = cmd.clr_en ? clr_r : probe_r;
  assign wr_data = cmd.clr_en ? '0 : {epoch_r, prefix_r, sym_r, CODE_W'(nfc_r)};

  lzwse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Two-entry result queue.
  logic [lzwse_pkg::OUT_CODE_W-1:0] q_code_r [2];
  logic                             q_last_r [2];
  logic                             q_head_r;
  logic [1:0]                       q_cnt_r;
  logic                             push, pop;
  logic                             q_slot;

  assign push      = cmd.miss | cmd.flush;
  assign pop       = out_valid && out_ready;
  assign q_slot    = q_head_r ^ q_cnt_r[0];
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_code  = q_code_r[q_head_r];
  assign out_last_code = q_last_r[q_head_r];

  assign status.prefix_valid = valid_r;
  assign status.last         = last_r;
  assign status.rd_match     = (rd_epoch == epoch_r) && (rd_pfx == prefix_r)
                               && (rd_sym == sym_r);
  assign status.rd_empty     = (rd_epoch != epoch_r);
  assign status.q_full       = (q_cnt_r == 2'd2);
  assign status.clr_done     = (clr_r == '1);
  assign status.epoch_wrap   = (epoch_r == '1);

  always_ff @(posedge clk) begin
    if (cmd.lookup || cmd.first_sym) begin
      sym_r  <= in_sym;
      last_r <= in_end_of_message;
    end
    if (cmd.lookup) begin
      probe_r <= hash_in;
    end else if (cmd.probe_next) begin
      probe_r <= probe_r + TBL_AW'(1);
    end
    if (push) begin
      q_code_r[q_slot] <= lzwse_pkg::OUT_CODE_W'(prefix_r);
      q_last_r[q_slot] <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      valid_r  <= 1'b0;
      nfc_r    <= NFC_W'(ALPHABET);
      epoch_r  <= EP_W'(1);
      clr_r    <= '0;
      q_head_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (cmd.clr_en) begin
        clr_r <= clr_r + TBL_AW'(1);
      end
      if (cmd.first_sym) begin
        prefix_r <= CODE_W'(in_sym);
        valid_r  <= 1'b1;
      end else if (cmd.hit) begin
        prefix_r <= rd_code;
      end else if (cmd.miss) begin
        prefix_r <= CODE_W'(sym_r);
        if (room) begin
          nfc_r <= nfc_r + NFC_W'(1);
        end
      end else if (cmd.flush) begin
        prefix_r <= '0;
        valid_r  <= 1'b0;
        nfc_r    <= NFC_W'(ALPHABET);
        epoch_r  <= status.epoch_wrap ? EP_W'(1) : epoch_r + EP_W'(1);
      end
      if (pop) begin
        q_head_r <= ~q_head_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/lzw_stream_encoder.sv =====
// LZW stream encoder with 12-bit output codes.
// The input channel (in_valid, in_ready, in_symbol, in_end_of_message) takes one
// symbol per transfer; in_end_of_message marks the final symbol of a message.
// The output channel (out_valid, out_ready, out_code, out_last_code) delivers the
// emitted codes in order; out_last_code marks the flushed final code.
// The dictionary is an open-addressed hash table in one memory with twice
// DICT_SIZE slots, each tagged with a message generation mark, so a new
// message starts with an empty dictionary without touching the memory.
// Each symbol is accepted in ST_IDLE and then looked up in ST_CHECK, which also
// steps past each occupied slot on the probe chain one read at a time, as the
// table has a single read port; a new symbol is taken only after ST_CHECK is left.
// The first symbol of a message needs no lookup. A final symbol adds the flush.
// A miss code enters the result queue from ST_CHECK and is presented from there.
// Reset starts a clearing pass over all 2**(clog2(DICT_SIZE)+1) slots (8192 at the
// default size) during which in_ready stays low; the same pass runs again after
// every 255th message, when the generation mark wraps.
// A two-entry result queue separates the channels: while the receiver stalls,
// symbols that hit keep being taken; a symbol that must emit into a full queue
// holds the block until the receiver takes a code.
module lzw_stream_encoder #(
  parameter int DICT_SIZE = 4096,
  parameter int ALPHABET  = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lzwse_pkg::IN_SYM_W-1:0]   in_symbol,
  input  logic                             in_end_of_message,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lzwse_pkg::OUT_CODE_W-1:0] out_code,
  output logic                             out_last_code
);

  // Command and status between the sequencer and the datapath.
  lzwse_pkg::cmd_t    cmd;
  lzwse_pkg::status_t status;

  // The sequencer owns the input handshake and steps each symbol through
  // lookup, probing, emission and the end-of-message flush.
  lzwse_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .status            (status),
    .cmd               (cmd)
  );

  // The datapath holds the prefix, the code counter, the hash table and the
  // result queue that drives the output channel.
  lzwse_dp #(
    .DICT_SIZE (DICT_SIZE),
    .ALPHABET  (ALPHABET)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_symbol         (in_symbol),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code          (out_code),
    .out_last_code     (out_last_code),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
